@@ design/rvcov_pkg.sv @@
// ----------------------------------------------------------------------------
// rvcov_pkg
// Shared types and encodings for the RV64IMA instruction coverage monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package rvcov_pkg;

  localparam int NumClasses = 99;
  localparam int ClassW     = 7;
  localparam int WordW      = 32;

  // major opcodes
  localparam logic [6:0] OPC_MASK    = 7'h7F;
  localparam logic [6:0] OPC_LUI     = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
  localparam logic [6:0] OPC_JAL     = 7'b1101111;
  localparam logic [6:0] OPC_JALR    = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
  localparam logic [6:0] OPC_LOAD    = 7'b0000011;
  localparam logic [6:0] OPC_STORE   = 7'b0100011;
  localparam logic [6:0] OPC_OP_IMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP_IMM32 = 7'b0011011;
  localparam logic [6:0] OPC_OP      = 7'b0110011;
  localparam logic [6:0] OPC_OP32    = 7'b0111011;
  localparam logic [6:0] OPC_AMO     = 7'b0101111;
  localparam logic [6:0] OPC_SYSTEM  = 7'b1110011;
  localparam logic [6:0] OPC_FENCE   = 7'b0001111;

  // funct7 / funct6 codes
  localparam logic [6:0] F7_BASE  = 7'b0000000;
  localparam logic [6:0] F7_ALT   = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;
  localparam logic [6:0] F7_SFENCE = 7'b0001001;
  localparam logic [5:0] F6_SRLI  = 6'b000000;
  localparam logic [5:0] F6_SRAI  = 6'b010000;

  // AMO funct5 codes
  localparam logic [4:0] AMO_LR   = 5'h02;
  localparam logic [4:0] AMO_SC   = 5'h03;
  localparam logic [4:0] AMO_SWAP = 5'h01;
  localparam logic [4:0] AMO_ADD  = 5'h00;
  localparam logic [4:0] AMO_XOR  = 5'h04;
  localparam logic [4:0] AMO_AND  = 5'h0C;
  localparam logic [4:0] AMO_OR   = 5'h08;
  localparam logic [4:0] AMO_MIN  = 5'h10;
  localparam logic [4:0] AMO_MAX  = 5'h14;
  localparam logic [4:0] AMO_MINU = 5'h18;
  localparam logic [4:0] AMO_MAXU = 5'h1C;

  // exact SYSTEM words
  localparam logic [31:0] W_ECALL  = 32'h00000073;
  localparam logic [31:0] W_EBREAK = 32'h00100073;
  localparam logic [31:0] W_URET   = 32'h00200073;
  localparam logic [31:0] W_SRET   = 32'h10200073;
  localparam logic [31:0] W_MRET   = 32'h30200073;
  localparam logic [31:0] W_WFI    = 32'h10500073;

  // class indexes of group bases and single classes
  localparam logic [6:0] CL_LUI     = 7'd0;
  localparam logic [6:0] CL_AUIPC   = 7'd1;
  localparam logic [6:0] CL_JAL     = 7'd2;
  localparam logic [6:0] CL_JALR    = 7'd3;
  localparam logic [6:0] CL_BEQ     = 7'd4;
  localparam logic [6:0] CL_BNE     = 7'd5;
  localparam logic [6:0] CL_BLT     = 7'd6;
  localparam logic [6:0] CL_BGE     = 7'd7;
  localparam logic [6:0] CL_BLTU    = 7'd8;
  localparam logic [6:0] CL_BGEU    = 7'd9;
  localparam logic [6:0] CL_LOAD    = 7'd10;
  localparam logic [6:0] CL_STORE   = 7'd17;
  localparam logic [6:0] CL_ADDI    = 7'd21;
  localparam logic [6:0] CL_SLTI    = 7'd22;
  localparam logic [6:0] CL_SLTIU   = 7'd23;
  localparam logic [6:0] CL_XORI    = 7'd24;
  localparam logic [6:0] CL_ORI     = 7'd25;
  localparam logic [6:0] CL_ANDI    = 7'd26;
  localparam logic [6:0] CL_SLLI    = 7'd27;
  localparam logic [6:0] CL_SRLI    = 7'd28;
  localparam logic [6:0] CL_SRAI    = 7'd29;
  localparam logic [6:0] CL_ADDIW   = 7'd30;
  localparam logic [6:0] CL_SLLIW   = 7'd31;
  localparam logic [6:0] CL_SRLIW   = 7'd32;
  localparam logic [6:0] CL_SRAIW   = 7'd33;
  localparam logic [6:0] CL_ADD     = 7'd34;
  localparam logic [6:0] CL_SUB     = 7'd35;
  localparam logic [6:0] CL_SLL     = 7'd36;
  localparam logic [6:0] CL_SLT     = 7'd37;
  localparam logic [6:0] CL_SLTU    = 7'd38;
  localparam logic [6:0] CL_XOR     = 7'd39;
  localparam logic [6:0] CL_SRL     = 7'd40;
  localparam logic [6:0] CL_SRA     = 7'd41;
  localparam logic [6:0] CL_OR      = 7'd42;
  localparam logic [6:0] CL_AND     = 7'd43;
  localparam logic [6:0] CL_ADDW    = 7'd44;
  localparam logic [6:0] CL_SUBW    = 7'd45;
  localparam logic [6:0] CL_SLLW    = 7'd46;
  localparam logic [6:0] CL_SRLW    = 7'd47;
  localparam logic [6:0] CL_SRAW    = 7'd48;
  localparam logic [6:0] CL_MULDIV  = 7'd49;
  localparam logic [6:0] CL_MULW    = 7'd57;
  localparam logic [6:0] CL_DIVW    = 7'd58;
  localparam logic [6:0] CL_DIVUW   = 7'd59;
  localparam logic [6:0] CL_REMW    = 7'd60;
  localparam logic [6:0] CL_REMUW   = 7'd61;
  localparam logic [6:0] CL_AMO_W   = 7'd62;
  localparam logic [6:0] CL_AMO_D   = 7'd73;
  localparam logic [6:0] CL_CSR_LO  = 7'd83;  // csrrw..csrrc at base + funct3
  localparam logic [6:0] CL_CSR_HI  = 7'd82;  // csrrwi..csrrci at base + funct3
  localparam logic [6:0] CL_ECALL   = 7'd90;
  localparam logic [6:0] CL_EBREAK  = 7'd91;
  localparam logic [6:0] CL_URET    = 7'd92;
  localparam logic [6:0] CL_SRET    = 7'd93;
  localparam logic [6:0] CL_MRET    = 7'd94;
  localparam logic [6:0] CL_WFI     = 7'd95;
  localparam logic [6:0] CL_SFENCE  = 7'd96;
  localparam logic [6:0] CL_FENCE   = 7'd97;
  localparam logic [6:0] CL_FENCE_I = 7'd98;

  typedef struct packed {
    logic              known;
    logic [ClassW-1:0] idx;
  } rvcov_decode_t;

  // packed lowest field last, so it lands in the low bits of tdata
  typedef struct packed {
    logic [WordW-1:0]  last_unknown_word;
    logic              unknown_seen;
    logic [ClassW-1:0] classes_covered;
    logic              first_time;
    logic              recognized;
    logic [ClassW-1:0] class_index;
  } rvcov_result_t;

endpackage

`default_nettype wire

@@ design/rvcov_decode.sv @@
// ----------------------------------------------------------------------------
// rvcov_decode
// Maps one 32-bit instruction word to its coverage class.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcov_decode
  import rvcov_pkg::*;
(
  input  wire logic [WordW-1:0] word,
  output rvcov_decode_t         dec
);

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] f6;
  logic [4:0] f5;
  logic [6:0] f3x;
  logic       amo_ok;
  logic [6:0] amo_slot;

  assign op  = word[6:0] & OPC_MASK;
  assign f3  = word[14:12];
  assign f7  = word[31:25];
  assign f6  = word[31:26];
  assign f5  = word[31:27];
  assign f3x = {4'b0, f3};

  always_comb begin
    amo_ok   = 1'b1;
    amo_slot = 7'd0;
    case (f5)
      AMO_LR:   amo_slot = 7'd0;
      AMO_SC:   amo_slot = 7'd1;
      AMO_SWAP: amo_slot = 7'd2;
      AMO_ADD:  amo_slot = 7'd3;
      AMO_XOR:  amo_slot = 7'd4;
      AMO_AND:  amo_slot = 7'd5;
      AMO_OR:   amo_slot = 7'd6;
      AMO_MIN:  amo_slot = 7'd7;
      AMO_MAX:  amo_slot = 7'd8;
      AMO_MINU: amo_slot = 7'd9;
      AMO_MAXU: amo_slot = 7'd10;
      default:  amo_ok   = 1'b0;
    endcase
  end

  always_comb begin
    dec.known = 1'b1;
    dec.idx   = CL_LUI;
    case (op)
      OPC_LUI:   dec.idx = CL_LUI;
      OPC_AUIPC: dec.idx = CL_AUIPC;
      OPC_JAL:   dec.idx = CL_JAL;
      OPC_JALR:  dec.idx = CL_JALR;
      OPC_BRANCH: begin
        case (f3)
          3'd0: dec.idx = CL_BEQ;
          3'd1: dec.idx = CL_BNE;
          3'd4: dec.idx = CL_BLT;
          3'd5: dec.idx = CL_BGE;
          3'd6: dec.idx = CL_BLTU;
          3'd7: dec.idx = CL_BGEU;
          default: dec.known = 1'b0;
        endcase
      end
      OPC_LOAD: begin
        dec.known = (f3 != 3'd7);
        dec.idx   = CL_LOAD + f3x;
      end
      OPC_STORE: begin
        dec.known = !f3[2];
        dec.idx   = CL_STORE + f3x;
      end
      OPC_OP_IMM: begin
        case (f3)
          3'd0: dec.idx = CL_ADDI;
          3'd1: dec.idx = CL_SLLI;
          3'd2: dec.idx = CL_SLTI;
          3'd3: dec.idx = CL_SLTIU;
          3'd4: dec.idx = CL_XORI;
          3'd6: dec.idx = CL_ORI;
          3'd7: dec.idx = CL_ANDI;
          default: begin
            // rv64 shift amount is six bits, so only instr[31:26] is checked
            if (f6 == F6_SRLI) begin
              dec.idx = CL_SRLI;
            end else if (f6 == F6_SRAI) begin
              dec.idx = CL_SRAI;
            end else begin
              dec.known = 1'b0;
            end
          end
        endcase
      end
      OPC_OP_IMM32: begin
        case (f3)
          3'd0: dec.idx = CL_ADDIW;
          3'd1: dec.idx = CL_SLLIW;
          3'd5: begin
            if (f7 == F7_BASE) begin
              dec.idx = CL_SRLIW;
            end else if (f7 == F7_ALT) begin
              dec.idx = CL_SRAIW;
            end else begin
              dec.known = 1'b0;
            end
          end
          default: dec.known = 1'b0;
        endcase
      end
      OPC_OP: begin
        if (f7 == F7_MULDIV) begin
          dec.idx = CL_MULDIV + f3x;
        end else begin
          case (f3)
            3'd0: begin
              if (f7 == F7_BASE) begin
                dec.idx = CL_ADD;
              end else if (f7 == F7_ALT) begin
                dec.idx = CL_SUB;
              end else begin
                dec.known = 1'b0;
              end
            end
            3'd1: dec.idx = CL_SLL;
            3'd2: dec.idx = CL_SLT;
            3'd3: dec.idx = CL_SLTU;
            3'd4: dec.idx = CL_XOR;
            3'd5: begin
              if (f7 == F7_BASE) begin
                dec.idx = CL_SRL;
              end else if (f7 == F7_ALT) begin
                dec.idx = CL_SRA;
              end else begin
                dec.known = 1'b0;
              end
            end
            3'd6: dec.idx = CL_OR;
            default: dec.idx = CL_AND;
          endcase
        end
      end
      OPC_OP32: begin
        if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0: dec.idx = CL_MULW;
            3'd4: dec.idx = CL_DIVW;
            3'd5: dec.idx = CL_DIVUW;
            3'd6: dec.idx = CL_REMW;
            3'd7: dec.idx = CL_REMUW;
            default: dec.known = 1'b0;
          endcase
        end else begin
          case (f3)
            3'd0: begin
              if (f7 == F7_BASE) begin
                dec.idx = CL_ADDW;
              end else if (f7 == F7_ALT) begin
                dec.idx = CL_SUBW;
              end else begin
                dec.known = 1'b0;
              end
            end
            3'd1: dec.idx = CL_SLLW;
            3'd5: begin
              if (f7 == F7_BASE) begin
                dec.idx = CL_SRLW;
              end else if (f7 == F7_ALT) begin
                dec.idx = CL_SRAW;
              end else begin
                dec.known = 1'b0;
              end
            end
            default: dec.known = 1'b0;
          endcase
        end
      end
      OPC_AMO: begin
        if (amo_ok && f3 == 3'd2) begin
          dec.idx = CL_AMO_W + amo_slot;
        end else if (amo_ok && f3 == 3'd3) begin
          dec.idx = CL_AMO_D + amo_slot;
        end else begin
          dec.known = 1'b0;
        end
      end
      OPC_SYSTEM: begin
        if (f3 == 3'd0) begin
          if (word == W_ECALL) begin
            dec.idx = CL_ECALL;
          end else if (word == W_EBREAK) begin
            dec.idx = CL_EBREAK;
          end else if (word == W_URET) begin
            dec.idx = CL_URET;
          end else if (word == W_SRET) begin
            dec.idx = CL_SRET;
          end else if (word == W_MRET) begin
            dec.idx = CL_MRET;
          end else if (word == W_WFI) begin
            dec.idx = CL_WFI;
          end else if (f7 == F7_SFENCE) begin
            dec.idx = CL_SFENCE;
          end else begin
            dec.known = 1'b0;
          end
        end else if (f3 == 3'd4) begin
          dec.known = 1'b0;
        end else if (!f3[2]) begin
          dec.idx = CL_CSR_LO + f3x;
        end else begin
          dec.idx = CL_CSR_HI + f3x;
        end
      end
      OPC_FENCE: begin
        if (f3 == 3'd0) begin
          dec.idx = CL_FENCE;
        end else if (f3 == 3'd1) begin
          dec.idx = CL_FENCE_I;
        end else begin
          dec.known = 1'b0;
        end
      end
      default: dec.known = 1'b0;
    endcase
    if (!dec.known) begin
      dec.idx = CL_LUI;
    end
  end

endmodule

`default_nettype wire

@@ design/rvcov_track.sv @@
// ----------------------------------------------------------------------------
// rvcov_track
// Sticky per-class seen bits, coverage count and unknown-word record.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcov_track
  import rvcov_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire rvcov_decode_t    dec,
  input  wire logic [WordW-1:0] word,
  output rvcov_result_t         res
);

  logic [NumClasses-1:0] class_seen;
  logic [ClassW-1:0]     covered_count;
  logic                  unknown_flag;
  logic [WordW-1:0]      unknown_word;

  logic [ClassW-1:0]     covered_count_next;
  logic                  unknown_flag_next;
  logic [WordW-1:0]      unknown_word_next;
  logic                  is_new;

  assign is_new = dec.known && !class_seen[dec.idx];

  always_comb begin
    covered_count_next = covered_count;
    unknown_flag_next  = unknown_flag;
    unknown_word_next  = unknown_word;
    if (is_new && covered_count < ClassW'(NumClasses)) begin
      covered_count_next = covered_count + 1'b1;
    end
    if (!dec.known) begin
      unknown_flag_next = 1'b1;
      unknown_word_next = word;
    end
  end

  always_comb begin
    res.class_index       = dec.idx;
    res.recognized        = dec.known;
    res.first_time        = is_new;
    res.classes_covered   = covered_count_next;
    res.unknown_seen      = unknown_flag_next;
    res.last_unknown_word = unknown_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_seen    <= '0;
      covered_count <= '0;
      unknown_flag  <= 1'b0;
      unknown_word  <= '0;
    end else if (advance) begin
      if (dec.known) begin
        class_seen[dec.idx] <= 1'b1;
      end
      covered_count <= covered_count_next;
      unknown_flag  <= unknown_flag_next;
      unknown_word  <= unknown_word_next;
    end
  end

  // count always matches the seen bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    covered_count == ClassW'($countones(class_seen)))
    else $error("coverage count out of step with seen bits");

  a_new_is_known: assert property (@(posedge clk) disable iff (rst)
    advance && res.first_time |-> res.recognized && res.classes_covered != '0)
    else $error("new class flagged for an unknown word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && res.first_time |=> covered_count == $past(covered_count) + 1'b1)
    else $error("coverage count did not step on a new class");

  a_unknown_sticky: assert property (@(posedge clk) disable iff (rst)
    unknown_flag |=> unknown_flag)
    else $error("unknown flag dropped");

  a_unknown_record: assert property (@(posedge clk) disable iff (rst)
    advance && !dec.known |=> unknown_word == $past(word))
    else $error("unknown word not recorded");

endmodule

`default_nettype wire

@@ design/riscv_instruction_coverage_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// riscv_instruction_coverage_monitor_unit
// RV64IMA retired-instruction coverage monitor with stream ports.
// ----------------------------------------------------------------------------
// Takes one retired instruction word per transfer and returns one result per
// word: class index, new-class flag, running count of covered classes and the
// sticky unknown-word status. Throughput is one instruction per clock while the
// output is not stalled. A word taken on the input goes into the input register;
// decode and update then run from it into the result register, which drives
// the output. A stalled output holds at most two words (input and result
// register) before the input stops. The seen bits live in flip-flops cleared
// by rst, so the block is ready for transfers as soon as reset is released.
`default_nettype none

module riscv_instruction_coverage_monitor_unit
  import rvcov_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // instruction[31:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // class_index[6:0], recognized[7], first_time[8], classes_covered[15:9],
  // unknown_seen[16], last_unknown_word[48:17], zero fill[55:49]
  output logic [55:0]      m_axis_tdata
);

  logic             in_valid;
  logic [WordW-1:0] in_word;
  logic             out_valid;
  rvcov_result_t    out_res;
  logic             advance;
  rvcov_decode_t    dec;
  rvcov_result_t    res;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word <= s_axis_tdata;
    end
  end

  rvcov_decode u_decode (
    .word (in_word),
    .dec  (dec)
  );

  rvcov_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .dec     (dec),
    .word    (in_word),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_res};

endmodule

`default_nettype wire
